FILE: hdl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General clocked property, disabled while reset is asserted.
`define AST_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// A stalled request keeps its valid and its payload.
`define AST_HOLD(lbl, clk, rst_n, vld, rdy, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> ((vld) && $stable(sig))) \
        else $error("stalled request changed");

`endif

FILE: hdl/u8tr_pkg.sv
// Shared types and constants of the UTF-8 character transliterator.
`default_nettype none

package u8tr_pkg;

    localparam int CODE_W = 21;
    localparam int BYTE_W = 8;
    localparam int OFS_W  = 22;

    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_LOAD      = 1'b1;

    localparam logic [CODE_W-1:0] CODE_LIMIT = 21'h110000;

    typedef logic [CODE_W-1:0] code_t;

    // One finished code point handed to the encoder.
    typedef struct packed {
        logic  valid;
        code_t code;
    } char_req_t;

endpackage

`default_nettype wire

FILE: hdl/u8tr_encoder.sv
// UTF-8 encoder and byte serializer for translated code points.
`default_nettype none

module u8tr_encoder
(
    input  logic                clk,
    input  logic                rst_n,
    input  u8tr_pkg::char_req_t req,
    output logic                req_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast
);
    import u8tr_pkg::*;

    logic [4*BYTE_W-1:0] bytes_reg;
    logic [4*BYTE_W-1:0] bytes_next;
    logic [2:0]          cnt_reg;
    logic [2:0]          cnt_next;
    logic [4*BYTE_W-1:0] enc_bytes;
    logic [2:0]          enc_cnt;
    code_t               cp;

    // first byte in the low lane, shifted out low first
    always_comb
    begin
        cp = req.code;
        if (cp < 21'h80)
        begin
            enc_bytes = {24'd0, 1'b0, cp[6:0]};
            enc_cnt   = 3'd1;
        end
        else if (cp < 21'h800)
        begin
            enc_bytes = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
            enc_cnt   = 3'd2;
        end
        else if (cp < 21'h10000)
        begin
            enc_bytes = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
            enc_cnt   = 3'd3;
        end
        else
        begin
            enc_bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                         5'b11110, cp[20:18]};
            enc_cnt   = 3'd4;
        end
    end

    assign m_tvalid  = (cnt_reg != 3'd0);
    assign m_tdata   = bytes_reg[BYTE_W-1:0];
    assign m_tlast   = (cnt_reg == 3'd1);
    assign req_ready = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && m_tready);

    always_comb
    begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        if (req.valid && req_ready)
        begin
            bytes_next = enc_bytes;
            cnt_next   = enc_cnt;
        end
        else if (m_tvalid && m_tready)
        begin
            bytes_next = {8'd0, bytes_reg[4*BYTE_W-1:BYTE_W]};
            cnt_next   = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

endmodule

`default_nettype wire

FILE: hdl/utf8_char_transliterator.sv
// Top level of the UTF-8 character transliterator: decoder, offset table, encoder.
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tdata: data_byte, from_code, to_code; tuser: cmd
// m_*       out  m_tvalid/m_tready   tdata: out_byte; tlast: last_byte
//
// One request accepted per cycle while s_tready is high; a completed character
// goes through the table-read stage register, then the encoder register, to its
// first output byte. A character holds the encoder until its last byte is taken.
// The input stalls only while a clearing pass zeroes the offset table after reset
// or the table-read stage waits on the encoder, so ASCII runs at 1 per cycle with
// m_tready high. Loads write the table at acceptance and give no output.
`default_nettype none

module utf8_char_transliterator
#(
    parameter int TABLE_DEPTH = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,    // [7:0] data_byte, [28:8] from_code, [49:29] to_code
    input  logic        s_tuser,    // [0] cmd
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast     // last_byte
);
    import u8tr_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CODE_W:0]   DEPTH_V   = (CODE_W+1)'(TABLE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

    // input fields
    logic [7:0] data_byte;
    code_t      from_code;
    code_t      to_code;

    assign data_byte = s_tdata[7:0];
    assign from_code = s_tdata[28:8];
    assign to_code   = s_tdata[49:29];

    // clearing pass
    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;

    // decoder state
    code_t      partial_reg;
    code_t      partial_next;
    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    // table-read stage
    logic  s1_valid_reg;
    logic  s1_valid_next;
    code_t s1_code_reg;
    logic  s1_hit_reg;
    logic  s1_go;

    // offset table
    logic [OFS_W-1:0]  ofs_mem [TABLE_DEPTH];
    logic [OFS_W-1:0]  rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [OFS_W-1:0]  mem_wdata;
    logic              mem_re;

    logic      accept;
    logic      load_ok;
    logic      dec_done;
    code_t     dec_code;
    logic      dec_hit;
    code_t     sum_code;
    char_req_t enc_req;
    logic      enc_ready;

    assign accept   = s_tvalid && s_tready;
    assign s1_go    = s1_valid_reg && enc_ready;
    assign s_tready = !clr_busy_reg && (!s1_valid_reg || enc_ready);

    // byte decoder; a non-continuation byte always restarts the character
    always_comb
    begin
        dec_done     = 1'b0;
        dec_code     = partial_reg;
        partial_next = partial_reg;
        pend_next    = pend_reg;
        if (accept && (s_tuser == CMD_TRANSLATE))
        begin
            if (data_byte[7:6] == 2'b10)
            begin
                if (pend_reg != 2'd0)
                begin
                    partial_next = {partial_reg[CODE_W-7:0], data_byte[5:0]};
                    pend_next    = pend_reg - 2'd1;
                    if (pend_reg == 2'd1)
                    begin
                        dec_done = 1'b1;
                        dec_code = partial_next;
                    end
                end
            end
            else
            begin
                partial_next = '0;
                pend_next    = 2'd0;
                if (!data_byte[7])
                begin
                    dec_done = 1'b1;
                    dec_code = {13'd0, data_byte};
                end
                else if (data_byte[7:5] == 3'b110)
                begin
                    partial_next = {16'd0, data_byte[4:0]};
                    pend_next    = 2'd1;
                end
                else if (data_byte[7:4] == 4'b1110)
                begin
                    partial_next = {17'd0, data_byte[3:0]};
                    pend_next    = 2'd2;
                end
                else if (data_byte[7:3] == 5'b11110)
                begin
                    partial_next = {18'd0, data_byte[2:0]};
                    pend_next    = 2'd3;
                end
                // 0xF8..0xFF: dropped, partial already cleared
            end
        end
    end

    assign dec_hit = ({1'b0, dec_code} < DEPTH_V);

    // loads outside the table or the code space are ignored
    assign load_ok = accept && (s_tuser == CMD_LOAD) && ({1'b0, from_code} < DEPTH_V)
                     && (from_code < CODE_LIMIT) && (to_code < CODE_LIMIT);

    // one write port shared by the clearing pass and loads; never in the same cycle
    assign mem_we    = clr_busy_reg || load_ok;
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : from_code[ADDR_W-1:0];
    assign mem_wdata = clr_busy_reg ? '0 : ({1'b0, to_code} - {1'b0, from_code});
    assign mem_re    = dec_done && dec_hit;

    // read data register only moves on a new read, so it holds while stage 1 stalls
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ofs_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= ofs_mem[dec_code[ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = dec_done;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // offset add mod 2^21; the sign bit of the offset drops out
    assign sum_code = s1_hit_reg ? (s1_code_reg + rd_data_reg[CODE_W-1:0]) : s1_code_reg;

    assign enc_req.valid = s1_valid_reg;
    assign enc_req.code  = sum_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            partial_reg  <= '0;
            pend_reg     <= 2'd0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            partial_reg  <= partial_next;
            pend_reg     <= pend_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_code_reg <= dec_code;
            s1_hit_reg  <= dec_hit;
        end
    end

    u8tr_encoder u_encoder
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (enc_req),
        .req_ready (enc_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

FILE: hdl/u8tr_checker.sv
// Port-level checker for the transliterator output stream, with its bind.
`default_nettype none
`include "assert_macros.svh"

module u8tr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // a stalled output byte holds
    `AST_HOLD(a_out_hold, clk, rst_n, m_tvalid, m_tready, {m_tdata, m_tlast})

    // bytes before the last of a character are all multi-byte UTF-8 bytes
    `AST_PROP(a_mid_high, clk, rst_n, (m_tvalid && !m_tlast) |-> m_tdata[7])

    // once a non-final byte is taken, a continuation byte follows at once
    `AST_PROP(a_cont_next, clk, rst_n,
              (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && (m_tdata[7:6] == 2'b10)))

    // a lead byte never ends a character
    `AST_PROP(a_no_lead_last, clk, rst_n, (m_tvalid && m_tlast) |-> (m_tdata[7:6] != 2'b11))

endmodule

bind utf8_char_transliterator u8tr_checker u_chk (.*);

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the UTF-8 transliterator: table loads, byte decoding, re-encoding.
`timescale 1ns / 1ps

module testbench;

    import u8tr_pkg::*;

    localparam int TBL_DEPTH   = 4096;
    localparam int TEXT_ITEMS  = 420;
    localparam int CYCLE_LIMIT = 300000;

    // One request on the slave side: either a text byte or a mapping pair.
    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        code_t      from_cp;
        code_t      to_cp;
    } text_req_t;

    // One byte expected on the master side.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    // Receiver stall patterns, one picked at random whenever the current one runs out.
    typedef enum logic [1:0] {
        RDY_FULL,
        RDY_COIN,
        RDY_SPARSE,
        RDY_TOGGLE
    } rdy_mode_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    utf8_char_transliterator #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: offset table and the decoder's partial character.
    // ------------------------------------------------------------------
    logic [21:0] ofs_tbl [TBL_DEPTH];
    code_t       part_cp = '0;
    logic [1:0]  cont_left = '0;

    text_req_t   pending_reqs[$];   // requests not yet offered to the block
    out_beat_t   due_beats[$];      // bytes the block still owes us
    text_req_t   next_req;

    int          errors = 0;
    int          out_seen = 0;
    int          cycles = 0;

    task automatic report(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        errors++;
    endtask

    // UTF-8 byte sequence of a code point, sized by value; seq[0] goes first.
    function automatic void utf8_split(input code_t cp, output logic [3:0][7:0] seq,
                                       output int n);
        seq = '0;
        if (cp < 21'h80) begin
            seq[0] = cp[7:0];
            n = 1;
        end else if (cp < 21'h800) begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
            n = 2;
        end else if (cp < 21'h10000) begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
            n = 3;
        end else begin
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
            n = 4;
        end
    endfunction

    // A finished character: look up its offset (table range only) and queue
    // the re-encoded bytes.
    function automatic void emit_char(input code_t cp);
        logic [21:0]      sum;
        code_t            res;
        logic [3:0][7:0]  seq;
        int               n;
        res = cp;
        if (cp < TBL_DEPTH) begin
            sum = {1'b0, cp} + ofs_tbl[cp[11:0]];
            res = sum[20:0];
        end
        utf8_split(res, seq, n);
        for (int k = 0; k < n; k++)
            due_beats.push_back('{data: seq[k], last: (k == n - 1)});
    endfunction

    // Advance the predictor by one accepted request.
    function automatic void transliterate(input text_req_t req);
        if (req.cmd == CMD_LOAD) begin
            // out-of-range pairs are dropped silently
            if (req.from_cp < TBL_DEPTH && req.from_cp < CODE_LIMIT && req.to_cp < CODE_LIMIT)
                ofs_tbl[req.from_cp[11:0]] = {1'b0, req.to_cp} - {1'b0, req.from_cp};
            return;
        end
        if (req.data[7:6] == 2'b10) begin
            // stray continuation bytes vanish
            if (cont_left == 0)
                return;
            part_cp = {part_cp[14:0], req.data[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 0)
                emit_char(part_cp);
            return;
        end
        // anything else abandons a partial character and starts over
        cont_left = '0;
        part_cp = '0;
        if (!req.data[7]) begin
            emit_char({13'd0, req.data});
        end else if (req.data[7:5] == 3'b110) begin
            part_cp = {16'd0, req.data[4:0]};
            cont_left = 2'd1;
        end else if (req.data[7:4] == 4'b1110) begin
            part_cp = {17'd0, req.data[3:0]};
            cont_left = 2'd2;
        end else if (req.data[7:3] == 5'b11110) begin
            part_cp = {18'd0, req.data[2:0]};
            cont_left = 2'd3;
        end
        // 0xF8..0xFF: dropped, decoder already cleared
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers; unused fields carry random bits.
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b);
        pending_reqs.push_back('{cmd: CMD_TRANSLATE, data: b,
                                 from_cp: code_t'($urandom), to_cp: code_t'($urandom)});
    endtask

    task automatic queue_load(input code_t from_cp, input code_t to_cp);
        pending_reqs.push_back('{cmd: CMD_LOAD, data: 8'($urandom),
                                 from_cp: from_cp, to_cp: to_cp});
    endtask

    // Well-formed character, or only its first cut_at bytes when cut_at > 0.
    task automatic queue_char(input code_t cp, input int cut_at);
        logic [3:0][7:0] seq;
        int              n;
        utf8_split(cp, seq, n);
        if (cut_at > 0 && cut_at < n)
            n = cut_at;
        for (int k = 0; k < n; k++)
            queue_byte(seq[k]);
    endtask

    // Code point spread over all encoded sizes, weighted toward the table.
    function automatic code_t pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return code_t'($urandom_range(0, 21'h7F));
        else if (r < 55)
            return code_t'($urandom_range(21'h80, 21'h7FF));
        else if (r < 75)
            return code_t'($urandom_range(21'h800, TBL_DEPTH - 1));
        else if (r < 88)
            return code_t'($urandom_range(TBL_DEPTH, 21'hFFFF));
        else
            return code_t'($urandom_range(21'h10000, 21'h1FFFFF));
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of requests with random gaps; holds while stalled.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= 1'b0;
            burst_left <= 8;
            gap_left   <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                next_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {6'd0, next_req.to_cp, next_req.from_cp, next_req.data};
                s_tuser  <= next_req.cmd;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    // a quarter of bursts run back to back
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: rotating stall pattern, plus two long hold-offs that let
    // the block back up into its input.
    // ------------------------------------------------------------------
    int        hold_left = 0;
    int        holds_done = 0;
    rdy_mode_e rdy_mode = RDY_FULL;
    int        mode_left = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && out_seen >= (holds_done == 0 ? 40 : 500)) begin
            hold_left  <= 400;
            holds_done <= holds_done + 1;
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready  <= 1'b0;
            rdy_mode  <= RDY_FULL;
            mode_left <= 64;
        end else begin
            if (mode_left == 0) begin
                rdy_mode  <= rdy_mode_e'($urandom_range(0, 3));
                mode_left <= $urandom_range(16, 96);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rdy_mode)
                RDY_FULL:   m_tready <= (hold_left == 0);
                RDY_COIN:   m_tready <= (hold_left == 0) && $urandom_range(0, 1);
                RDY_SPARSE: m_tready <= (hold_left == 0) && ($urandom_range(0, 3) == 0);
                default:    m_tready <= (hold_left == 0) && !m_tready;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check output bytes first, then feed the accepted request to
    // the predictor. Output lags input by the table-read and encoder registers,
    // so a request accepted at this edge never owes a byte at this same edge.
    // ------------------------------------------------------------------
    out_beat_t got_exp;

    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                if (due_beats.size() == 0) begin
                    report($sformatf("unexpected byte %02h last=%0b", m_tdata, m_tlast));
                end else begin
                    got_exp = due_beats.pop_front();
                    if (m_tdata !== got_exp.data)
                        report($sformatf("out_byte %02h, want %02h", m_tdata, got_exp.data));
                    if (m_tlast !== got_exp.last)
                        report($sformatf("last_byte %0b on %02h, want %0b",
                                         m_tlast, m_tdata, got_exp.last));
                end
                out_seen++;
            end
            if (s_tvalid && s_tready)
                transliterate('{cmd: s_tuser, data: s_tdata[7:0],
                                from_cp: s_tdata[28:8], to_cp: s_tdata[49:29]});
        end
    end

    // Watchdog; covers the clearing pass after reset as well.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        int    pick;
        int    lsel;
        code_t cp;
        code_t from_cp;
        code_t to_cp;

        foreach (ofs_tbl[i])
            ofs_tbl[i] = '0;

        // directed: table edges, dropped loads, every byte class
        queue_load(21'h41, 21'h10FFFF);         // 'A' becomes the top code point
        queue_load(code_t'(TBL_DEPTH - 1), 21'h0); // last entry maps to NUL
        queue_load(code_t'(TBL_DEPTH), 21'h41); // from past the table: ignored
        queue_load(21'h42, CODE_LIMIT);         // to past Unicode: ignored
        queue_load(21'h1FFFFF, 21'h1FFFFF);     // both fields all ones: ignored
        queue_byte(8'h00);
        queue_byte(8'h7F);
        queue_byte(8'h41);
        queue_byte(8'h42);
        queue_byte(8'h80);                      // stray continuation
        queue_char(21'h7FF, 0);
        queue_char(code_t'(TBL_DEPTH - 1), 0);  // three bytes in, one out
        queue_byte(8'hC3);                      // cut short by 'A'
        queue_byte(8'h41);
        queue_byte(8'hF8);                      // invalid leads
        queue_byte(8'hFF);
        queue_char(21'h1FFFFF, 0);              // F7 lead, passes through
        queue_char(21'hFFFF, 0);

        // random: mostly well-formed characters, some loads, cut-off
        // sequences and raw noise
        while (pending_reqs.size() < TEXT_ITEMS + 26) begin
            pick = $urandom_range(0, 99);
            if (pick < 14) begin
                lsel = $urandom_range(0, 9);
                from_cp = $urandom_range(0, 1) ? code_t'($urandom_range(0, 255))
                                               : code_t'($urandom_range(0, TBL_DEPTH - 1));
                if (lsel < 6) begin
                    to_cp = $urandom_range(0, 1) ? pick_code()
                                                 : code_t'($urandom_range(0, 21'h10FFFF));
                end else if (lsel < 8) begin
                    from_cp = code_t'($urandom);
                    to_cp   = code_t'($urandom);
                end else begin
                    to_cp = code_t'($urandom_range(CODE_LIMIT, 21'h1FFFFF));
                end
                queue_load(from_cp, to_cp);
            end else if (pick < 24) begin
                queue_byte(8'($urandom));
            end else if (pick < 32) begin
                cp = pick_code() | 21'h80;
                queue_char(cp, $urandom_range(1, 3));
            end else begin
                queue_char(pick_code(), 0);
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // sampled on the falling edge so the sender's updates have settled
        while (pending_reqs.size() != 0 || s_tvalid || due_beats.size() != 0)
            @(negedge clk);
        repeat (16) @(posedge clk);

        if (due_beats.size() != 0)
            report($sformatf("%0d expected bytes never arrived", due_beats.size()));
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/u8tr_pkg.sv
hdl/u8tr_encoder.sv
hdl/utf8_char_transliterator.sv
hdl/u8tr_checker.sv
bench/testbench.sv
